>>> hw/rtl/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, trig, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (conseq)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEXT(label, clk, rst_n, trig, conseq, msg)

`endif

`endif

>>> hw/rtl/nfcs_pkg.sv
`timescale 1ns / 1ps

package nfcs_pkg;

    localparam int ADR_W  = 32;
    localparam int DAT_W  = 32;
    localparam int POLL_W = 13;
    localparam int IDX_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam int DQ6_LO = 6;
    localparam int DQ6_HI = 22;

    localparam logic [1:0] MODE_PROG  = 2'd0;
    localparam logic [1:0] MODE_ERASE = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;
    localparam logic [1:0] MODE_RESP  = 2'd3;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 13'd7000;

    localparam logic [DAT_W-1:0] CMD_UNLOCK1      = 32'h00aa00aa;
    localparam logic [DAT_W-1:0] CMD_UNLOCK2      = 32'h00550055;
    localparam logic [DAT_W-1:0] CMD_ERASE_SETUP  = 32'h00800080;
    localparam logic [DAT_W-1:0] CMD_SECTOR_ERASE = 32'h00300030;
    localparam logic [DAT_W-1:0] CMD_PROGRAM      = 32'h00a000a0;
    localparam logic [DAT_W-1:0] CMD_RESET        = 32'h00f000f0;

    localparam logic [10:0] OFS_A = 11'h555;
    localparam logic [10:0] OFS_B = 11'h2aa;

    typedef struct packed {
        logic [1:0]       mode;
        logic [ADR_W-1:0] address;
        logic [DAT_W-1:0] data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ADR_W-1:0] bus_address;
        logic [DAT_W-1:0] bus_data;
        logic             fail;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [ADR_W-1:0]  base_address;
        logic [1:0]        address_shift;
        logic [POLL_W-1:0] poll_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        SQ_PROG  = 3'd0,
        SQ_ERASE = 3'd1,
        SQ_RESET = 3'd2,
        SQ_READ  = 3'd3,
        SQ_FIN   = 3'd4
    } t_seq;

    typedef struct packed {
        logic             load;
        t_seq             seq;
        logic [ADR_W-1:0] adr;
        logic [DAT_W-1:0] dat;
        logic             fail;
        logic             erase;
    } t_burst;

    function automatic logic [IDX_W-1:0] seq_len(t_seq s, logic erase);
        logic [IDX_W-1:0] n;
        case (s)
            SQ_PROG:  n = 3'd5;
            SQ_ERASE: n = 3'd7;
            SQ_FIN:   n = erase ? 3'd2 : 3'd1;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic t_out_item res_at(t_burst b, logic [IDX_W-1:0] idx, t_cfg cfg);
        logic [ADR_W-1:0] a555;
        logic [ADR_W-1:0] a2aa;
        t_out_item r;
        a555 = cfg.base_address + ({21'd0, OFS_A} << cfg.address_shift);
        a2aa = cfg.base_address + ({21'd0, OFS_B} << cfg.address_shift);
        r = '0;
        r.kind = KIND_WRITE;
        case (b.seq)
            SQ_PROG: begin
                case (idx)
                    3'd0: begin r.bus_address = a555; r.bus_data = CMD_UNLOCK1; end
                    3'd1: begin r.bus_address = a2aa; r.bus_data = CMD_UNLOCK2; end
                    3'd2: begin r.bus_address = a555; r.bus_data = CMD_PROGRAM; end
                    3'd3: begin r.bus_address = b.adr; r.bus_data = b.dat; end
                    default: begin r.kind = KIND_READ; r.bus_address = b.adr; end
                endcase
            end
            SQ_ERASE: begin
                case (idx)
                    3'd0: begin r.bus_address = a555; r.bus_data = CMD_UNLOCK1; end
                    3'd1: begin r.bus_address = a2aa; r.bus_data = CMD_UNLOCK2; end
                    3'd2: begin r.bus_address = a555; r.bus_data = CMD_ERASE_SETUP; end
                    3'd3: begin r.bus_address = a555; r.bus_data = CMD_UNLOCK1; end
                    3'd4: begin r.bus_address = a2aa; r.bus_data = CMD_UNLOCK2; end
                    3'd5: begin r.bus_address = b.adr; r.bus_data = CMD_SECTOR_ERASE; end
                    default: begin r.kind = KIND_READ; r.bus_address = b.adr; end
                endcase
            end
            SQ_RESET: begin
                r.bus_address = cfg.base_address;
                r.bus_data    = CMD_RESET;
            end
            SQ_READ: begin
                r.kind        = KIND_READ;
                r.bus_address = b.adr;
            end
            default: begin
                if (b.erase && idx == 3'd0) begin
                    r.bus_address = cfg.base_address;
                    r.bus_data    = CMD_RESET;
                end else begin
                    r.kind        = KIND_DONE;
                    r.bus_address = b.adr;
                    r.fail        = b.fail;
                end
            end
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/nor_flash_command_sequencer.sv
`timescale 1ns / 1ps
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_ready     i_in_item
// out      output     o_out_valid / i_out_ready   o_out_item
// cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// an item waits in the input register; its results leave one per cycle unless stalled
// a program yields 5 results, an erase 7, a poll read 1, a finish 1 or 2
// the next item is taken as the last result of the current one is taken
// items that cause no result are dropped as soon as the output side is free
// synchronous active-low reset returns to idle with poll limit 7000
// a stalled output holds its item and the input register fills and waits

module nor_flash_command_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  nfcs_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output nfcs_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nfcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nfcs_pkg::DAT_W-1:0]     i_cfg_data
);
    import nfcs_pkg::*;

    t_cfg   w_cfg;
    t_burst w_burst;
    logic   w_take;

    nfcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .i_take      (w_take),
        .o_burst     (w_burst)
    );

    nfcs_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_burst (w_burst),
        .i_cfg   (w_cfg),
        .o_take  (w_take),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

>>> hw/rtl/nfcs_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nfcs_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  nfcs_pkg::t_in_item             i_in_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nfcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nfcs_pkg::DAT_W-1:0]     i_cfg_data,
    output nfcs_pkg::t_cfg                 o_cfg,
    input  logic                           i_take,
    output nfcs_pkg::t_burst               o_burst
);
    import nfcs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_FIRST  = 3'b010,
        PH_SECOND = 3'b100
    } t_phase;

    logic              r_in_valid;
    t_in_item          r_in;
    t_cfg              r_cfg;
    t_phase            r_phase, n_phase;
    logic              r_erase, n_erase;
    logic [POLL_W-1:0] r_poll, n_poll;
    logic [1:0]        r_tog, n_tog;
    logic [ADR_W-1:0]  r_target, n_target;

    logic              w_consume;
    logic              w_busy;
    logic [1:0]        w_tog;
    logic [POLL_W:0]   w_next;
    t_burst            w_burst;

    assign w_consume   = r_in_valid & i_take;
    assign o_in_ready  = ~r_in_valid | w_consume;
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign o_burst     = w_burst;

    assign w_busy = (r_phase != PH_IDLE);
    assign w_tog  = {r_in.data[DQ6_HI], r_in.data[DQ6_LO]};
    assign w_next = {1'b0, r_poll} + {{POLL_W{1'b0}}, 1'b1};

    always_comb begin
        n_phase  = r_phase;
        n_erase  = r_erase;
        n_poll   = r_poll;
        n_tog    = r_tog;
        n_target = r_target;
        w_burst       = '0;
        w_burst.seq   = SQ_READ;
        w_burst.adr   = r_target;
        w_burst.erase = r_erase;
        unique case (r_in.mode) inside
            MODE_PROG, MODE_ERASE: begin
                if (!w_busy) begin
                    w_burst.load = r_in_valid;
                    w_burst.seq  = (r_in.mode == MODE_ERASE) ? SQ_ERASE : SQ_PROG;
                    w_burst.adr  = r_in.address;
                    w_burst.dat  = r_in.data;
                    n_erase  = (r_in.mode == MODE_ERASE);
                    n_target = r_in.address;
                    n_poll   = '0;
                    n_tog    = '0;
                    n_phase  = PH_FIRST;
                end
            end
            MODE_RESET: begin
                if (!w_busy) begin
                    w_burst.load = r_in_valid;
                    w_burst.seq  = SQ_RESET;
                end
            end
            default: begin
                unique case (r_phase)
                    PH_FIRST: begin
                        w_burst.load = r_in_valid;
                        n_tog   = w_tog;
                        n_phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        w_burst.load = r_in_valid;
                        if (w_tog == r_tog || w_next >= {1'b0, r_cfg.poll_limit}) begin
                            w_burst.seq  = SQ_FIN;
                            w_burst.fail = (w_tog != r_tog);
                            n_phase = PH_IDLE;
                            n_poll  = '0;
                            n_tog   = '0;
                        end else begin
                            n_poll  = w_next[POLL_W-1:0];
                            n_phase = PH_FIRST;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address  <= '0;
            r_cfg.address_shift <= '0;
            r_cfg.poll_limit    <= POLL_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE:  r_cfg.base_address  <= i_cfg_data;
                CFG_SHIFT: r_cfg.address_shift <= i_cfg_data[1:0];
                CFG_LIMIT: r_cfg.poll_limit    <= i_cfg_data[POLL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_erase  <= 1'b0;
            r_poll   <= '0;
            r_tog    <= '0;
            r_target <= '0;
        end else if (w_consume) begin
            r_phase  <= n_phase;
            r_erase  <= n_erase;
            r_poll   <= n_poll;
            r_tog    <= n_tog;
            r_target <= n_target;
        end
    end

    `ASSERT_PROP(a_idle_clear, i_clk, i_rst_n, r_phase != PH_IDLE || (r_poll == '0 && r_tog == '0), "idle with stale poll state")
    `ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, w_consume && w_burst.load && w_burst.seq == SQ_FIN, r_phase == PH_IDLE, "finish did not return to idle")
    `ASSERT_PROP(a_resp_idle, i_clk, i_rst_n, !(r_in_valid && r_in.mode == MODE_RESP && r_phase == PH_IDLE) || !w_burst.load, "response while idle produced results")

endmodule

>>> hw/rtl/nfcs_emit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nfcs_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nfcs_pkg::t_burst    i_burst,
    input  nfcs_pkg::t_cfg      i_cfg,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_ready,
    output nfcs_pkg::t_out_item o_item
);
    import nfcs_pkg::*;

    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_cnt;
    t_burst           r_b;
    logic             w_fire;
    logic             w_last;
    t_out_item        w_item;

    assign w_last  = (r_idx == r_cnt - 3'd1);
    assign w_fire  = r_busy & i_ready;
    assign o_take  = ~r_busy | (w_fire & w_last);
    assign o_valid = r_busy;

    always_comb begin
        w_item      = res_at(r_b, r_idx, i_cfg);
        w_item.last = w_last;
        o_item      = w_item;
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_take) begin
            n_busy = i_burst.load;
            n_idx  = '0;
        end else if (w_fire) begin
            n_idx = r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_burst.load) begin
            r_b   <= i_burst;
            r_cnt <= seq_len(i_burst.seq, i_burst.erase);
        end
    end

    `ASSERT_PROP(a_idx_range, i_clk, i_rst_n, !r_busy || r_idx < r_cnt, "result index beyond burst")
    `ASSERT_PROP(a_done_last, i_clk, i_rst_n, !(o_valid && o_item.kind == KIND_DONE) || o_item.last, "done item is not last")
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(r_idx), "stalled burst advanced")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nfcs_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 12;

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_FIRST_READ  = 2'd1,
        PH_SECOND_READ = 2'd2
    } t_poll_state;

    class bus_op_scoreboard;
        logic [ADR_W-1:0]  base_adr;
        logic [1:0]        adr_shift;
        logic [POLL_W-1:0] poll_lim;
        t_poll_state       state;
        logic              erase_op;
        logic [POLL_W-1:0] pair_count;
        logic [1:0]        first_dq6;
        logic [ADR_W-1:0]  target_adr;
        t_out_item         expected_ops[$];
        t_out_item         staged[$];
        int                errors;

        function new();
            base_adr   = '0;
            adr_shift  = '0;
            poll_lim   = POLL_LIMIT_RST;
            state      = PH_IDLE;
            erase_op   = 1'b0;
            pair_count = '0;
            first_dq6  = '0;
            target_adr = '0;
            errors     = 0;
        endfunction

        task report_mismatch(string what, logic [ADR_W-1:0] got, logic [ADR_W-1:0] exp);
            $display("mismatch %s: got %h expected %h", what, got, exp);
            errors++;
        endtask

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [DAT_W-1:0] value);
            case (idx)
                CFG_BASE:  base_adr = value;
                CFG_SHIFT: adr_shift = value[1:0];
                CFG_LIMIT: poll_lim = value[POLL_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [ADR_W-1:0] cmd_address(logic [10:0] ofs);
            return base_adr + ({21'd0, ofs} << adr_shift);
        endfunction

        function logic [1:0] dq6_bits(logic [DAT_W-1:0] d);
            return {d[DQ6_HI], d[DQ6_LO]};
        endfunction

        function void stage(logic [1:0] kind, logic [ADR_W-1:0] adr, logic [DAT_W-1:0] dat,
                            logic fail);
            t_out_item r;
            r.kind        = kind;
            r.bus_address = adr;
            r.bus_data    = dat;
            r.fail        = fail;
            r.last        = 1'b0;
            staged.push_back(r);
        endfunction

        function void close_op(logic fail);
            if (erase_op)
                stage(KIND_WRITE, base_adr, CMD_RESET, 1'b0);
            stage(KIND_DONE, target_adr, '0, fail);
            state      = PH_IDLE;
            pair_count = '0;
            first_dq6  = '0;
        endfunction

        function void note_command(t_in_item it);
            logic        busy;
            logic [13:0] next_pairs;
            busy = (state != PH_IDLE);
            staged.delete();
            case (it.mode)
                MODE_PROG, MODE_ERASE: begin
                    if (!busy) begin
                        stage(KIND_WRITE, cmd_address(OFS_A), CMD_UNLOCK1, 1'b0);
                        stage(KIND_WRITE, cmd_address(OFS_B), CMD_UNLOCK2, 1'b0);
                        if (it.mode == MODE_PROG) begin
                            stage(KIND_WRITE, cmd_address(OFS_A), CMD_PROGRAM, 1'b0);
                            stage(KIND_WRITE, it.address, it.data, 1'b0);
                        end else begin
                            stage(KIND_WRITE, cmd_address(OFS_A), CMD_ERASE_SETUP, 1'b0);
                            stage(KIND_WRITE, cmd_address(OFS_A), CMD_UNLOCK1, 1'b0);
                            stage(KIND_WRITE, cmd_address(OFS_B), CMD_UNLOCK2, 1'b0);
                            stage(KIND_WRITE, it.address, CMD_SECTOR_ERASE, 1'b0);
                        end
                        stage(KIND_READ, it.address, '0, 1'b0);
                        erase_op   = (it.mode == MODE_ERASE);
                        target_adr = it.address;
                        pair_count = '0;
                        first_dq6  = '0;
                        state      = PH_FIRST_READ;
                    end
                end
                MODE_RESET: begin
                    if (!busy)
                        stage(KIND_WRITE, base_adr, CMD_RESET, 1'b0);
                end
                default: begin
                    if (state == PH_FIRST_READ) begin
                        first_dq6 = dq6_bits(it.data);
                        state     = PH_SECOND_READ;
                        stage(KIND_READ, target_adr, '0, 1'b0);
                    end else if (state == PH_SECOND_READ) begin
                        if (dq6_bits(it.data) == first_dq6) begin
                            close_op(1'b0);
                        end else begin
                            next_pairs = {1'b0, pair_count} + 14'd1;
                            if (next_pairs >= {1'b0, poll_lim}) begin
                                close_op(1'b1);
                            end else begin
                                pair_count = next_pairs[POLL_W-1:0];
                                state      = PH_FIRST_READ;
                                stage(KIND_READ, target_adr, '0, 1'b0);
                            end
                        end
                    end
                end
            endcase
            if (staged.size() > 0)
                staged[staged.size()-1].last = 1'b1;
            foreach (staged[i])
                expected_ops.push_back(staged[i]);
        endfunction

        task check_bus_op(t_out_item got);
            t_out_item exp;
            if (expected_ops.size() == 0) begin
                report_mismatch("unexpected item at address", got.bus_address, '0);
            end else begin
                exp = expected_ops.pop_front();
                if (got.kind !== exp.kind)
                    report_mismatch("kind", 32'(got.kind), 32'(exp.kind));
                if (got.bus_address !== exp.bus_address)
                    report_mismatch("bus_address", got.bus_address, exp.bus_address);
                if (got.bus_data !== exp.bus_data)
                    report_mismatch("bus_data", got.bus_data, exp.bus_data);
                if (got.fail !== exp.fail)
                    report_mismatch("fail", 32'(got.fail), 32'(exp.fail));
                if (got.last !== exp.last)
                    report_mismatch("last", 32'(got.last), 32'(exp.last));
            end
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DAT_W-1:0]     i_cfg_data  = '0;

    bus_op_scoreboard sb;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  out_quiet   = 1'b0;
    bit  in_quiet    = 1'b0;

    nor_flash_command_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL nor_flash_command_sequencer");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (!out_quiet && $urandom_range(0, 99) < 15) begin
            i_out_ready <= 1'b0;
            stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_bus_op(o_out_item);
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_quiet || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // mostly well-formed command / poll traffic, some ignored noise
    function t_in_item next_command(output bit counts);
        t_in_item it;
        int       r;
        it.address = pick_word();
        it.data    = pick_word();
        r = $urandom_range(0, 99);
        counts = 1'b1;
        if (sb.state == PH_IDLE) begin
            if (r < 40) begin
                it.mode = MODE_PROG;
            end else if (r < 80) begin
                it.mode = MODE_ERASE;
            end else if (r < 92) begin
                it.mode = MODE_RESET;
            end else begin
                it.mode = MODE_RESP;
                counts  = 1'b0;
            end
        end else begin
            if (r < 90) begin
                it.mode = MODE_RESP;
                if (sb.state == PH_SECOND_READ && $urandom_range(0, 1) == 1) begin
                    it.data[DQ6_LO] = sb.first_dq6[0];
                    it.data[DQ6_HI] = sb.first_dq6[1];
                end
            end else begin
                it.mode = 2'($urandom_range(0, 2));
                counts  = 1'b0;
            end
        end
        return it;
    endfunction

    task send_item(t_in_item it, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(it);
    endtask

    task send_cmd(logic [1:0] mode, logic [31:0] adr, logic [31:0] dat);
        t_in_item it;
        it.mode    = mode;
        it.address = adr;
        it.data    = dat;
        send_item(it, pick_gap());
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [DAT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, value);
    endtask

    task drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_ops.size() != 0);
    endtask

    initial begin
        t_in_item    it;
        bit          counts;
        int          n;
        bit          paused;
        logic [31:0] base_v;
        logic [1:0]  shift_v;
        logic [12:0] limit_v;

        sb     = new();
        paused = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset-value registers
        send_cmd(MODE_RESP,  32'h0000_0000, 32'h0000_0000);
        send_cmd(MODE_RESET, 32'hffff_ffff, 32'hffff_ffff);
        send_cmd(MODE_PROG,  32'h0000_0000, 32'h0000_0000);
        send_cmd(MODE_PROG,  32'hffff_ffff, 32'hffff_ffff);
        send_cmd(MODE_ERASE, 32'hffff_ffff, 32'hffff_ffff);
        send_cmd(MODE_RESET, 32'h0000_0000, 32'h0000_0000);
        send_cmd(MODE_RESP,  32'hffff_ffff, 32'h0000_0000);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'h0040_0040);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'hffff_ffff);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'h0040_0040);
        send_cmd(MODE_ERASE, 32'hffff_ffff, 32'hffff_ffff);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'h0000_0040);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'h0040_0000);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'h0040_0000);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'h0040_0000);
        send_cmd(MODE_PROG,  32'hffff_ffff, 32'hffff_ffff);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'hffff_ffff);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'hffbf_ffbf);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'h0000_0000);
        send_cmd(MODE_RESP,  32'h0000_0000, 32'h0000_0000);
        send_cmd(MODE_ERASE, 32'h1234_5678, 32'h0000_0000);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    base_v = 32'hffff_ffff; shift_v = 2'd2; limit_v = 13'd1;
                end
                1: begin
                    base_v = $urandom; shift_v = 2'd3; limit_v = 13'd0;
                end
                2: begin
                    base_v = 32'h0000_0000; shift_v = 2'd0; limit_v = 13'h1fff;
                end
                default: begin
                    base_v  = $urandom;
                    shift_v = 2'($urandom_range(0, 3));
                    limit_v = 13'($urandom_range(1, 5));
                end
            endcase
            write_reg(CFG_BASE, base_v);
            write_reg(CFG_SHIFT, {30'($urandom), shift_v});
            write_reg(CFG_LIMIT, {19'($urandom), limit_v});
            if (p == 0)
                write_reg(2'd3, $urandom);
            i_cfg_valid <= 1'b0;
            out_quiet = (p % 3 == 1);
            in_quiet  = (p % 3 == 2);

            n = 0;
            while (n < 50) begin
                if (p == 3 && n == 25 && !paused) begin
                    paused = 1'b1;
                    drain_results();
                end
                it = next_command(counts);
                send_item(it, pick_gap());
                n += counts;
            end
            drain_results();
            repeat (SETTLE) @(posedge i_clk);
        end

        if (sb.errors == 0 && sb.expected_ops.size() == 0)
            $display("PASS nor_flash_command_sequencer");
        else
            $display("FAIL nor_flash_command_sequencer");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/nfcs_pkg.sv
hw/rtl/nfcs_ctrl.sv
hw/rtl/nfcs_emit.sv
hw/rtl/nor_flash_command_sequencer.sv
tb/sv/tb_top.sv
